### rtl/tlv_stream_deframer_core_defines.svh
// Assertion macros for the TLV stream deframer.
`ifndef TLV_STREAM_DEFRAMER_CORE_DEFINES_SVH
`define TLV_STREAM_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TLVD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TLVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TLVD_ASSERT_IMPL(lbl, ante, cons, msg)
`define TLVD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/tlvd_pkg.sv
// Shared types and constants for the TLV stream deframer.
`default_nettype none

package tlvd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned HdrBytes  = 8;
  localparam int unsigned HdrPosW   = $clog2(HdrBytes);

  localparam logic [HdrPosW-1:0] HdrFirst = HdrPosW'(0);
  localparam logic [HdrPosW-1:0] HdrLast  = HdrPosW'(HdrBytes - 1);

  typedef struct packed {
    logic [WordW-1:0] msg_type;
    logic [WordW-1:0] msg_length;
    logic [ByteW-1:0] payload_byte;
    logic             first_byte;
    logic             last_byte;
    logic             empty_message;
  } result_t;

  typedef struct packed {
    logic               in_payload;
    logic [HdrPosW-1:0] hdr_pos;
  } status_t;

endpackage

`default_nettype wire

### rtl/tlvd_if.sv
// Stream interfaces for the TLV stream deframer: byte input and result output.
`default_nettype none

interface tlvd_in_if;
  logic                       valid;
  logic                       ready;
  logic [tlvd_pkg::ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tlvd_out_if;
  logic                       valid;
  logic                       ready;
  logic [tlvd_pkg::WordW-1:0] msg_type;
  logic [tlvd_pkg::WordW-1:0] msg_length;
  logic [tlvd_pkg::ByteW-1:0] payload_byte;
  logic                       first_byte;
  logic                       last_byte;
  logic                       empty_message;

  modport source (
    output valid, output msg_type, output msg_length, output payload_byte,
    output first_byte, output last_byte, output empty_message, input ready
  );
  modport sink (
    input valid, input msg_type, input msg_length, input payload_byte,
    input first_byte, input last_byte, input empty_message, output ready
  );
endinterface

`default_nettype wire

### rtl/tlvd_parser.sv
// Header collection and payload countdown for the TLV stream deframer.
`default_nettype none

module tlvd_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       beat_i,
  input  wire logic [tlvd_pkg::ByteW-1:0] data_byte_i,
  output logic                            res_valid_o,
  output tlvd_pkg::result_t               res_o,
  output tlvd_pkg::status_t               status_o
);

  logic                         in_payload_q, in_payload_d;
  logic [tlvd_pkg::HdrPosW-1:0] hdr_pos_q, hdr_pos_d;
  logic [tlvd_pkg::WordW-1:0]   type_q, type_d;
  logic [tlvd_pkg::WordW-1:0]   length_q, length_d;
  logic [tlvd_pkg::WordW-1:0]   remaining_q, remaining_d;

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_pos_d    = hdr_pos_q;
    type_d       = type_q;
    length_d     = length_q;
    remaining_d  = remaining_q;
    res_valid_o  = 1'b0;

    res_o.msg_type      = type_q;
    res_o.msg_length    = length_q;
    res_o.payload_byte  = data_byte_i;
    res_o.first_byte    = (remaining_q == length_q);
    res_o.last_byte     = (remaining_q == tlvd_pkg::WordW'(1));
    res_o.empty_message = 1'b0;

    if (in_payload_q) begin
      res_valid_o = 1'b1;
      remaining_d = remaining_q - tlvd_pkg::WordW'(1);
      // final payload byte: back to header collection
      if (remaining_q == tlvd_pkg::WordW'(1)) begin
        in_payload_d = 1'b0;
        hdr_pos_d    = tlvd_pkg::HdrFirst;
      end
    end else begin
      // bytes 0..3 fill the type, 4..7 the length, little-endian
      if (hdr_pos_q[tlvd_pkg::HdrPosW-1]) begin
        length_d[{hdr_pos_q[1:0], 3'b000} +: tlvd_pkg::ByteW] = data_byte_i;
      end else begin
        type_d[{hdr_pos_q[1:0], 3'b000} +: tlvd_pkg::ByteW] = data_byte_i;
      end
      hdr_pos_d = hdr_pos_q + tlvd_pkg::HdrPosW'(1);

      if (hdr_pos_q == tlvd_pkg::HdrLast) begin
        hdr_pos_d = tlvd_pkg::HdrFirst;
        if (length_d == '0) begin
          res_valid_o         = 1'b1;
          res_o.msg_length    = '0;
          res_o.payload_byte  = '0;
          res_o.first_byte    = 1'b1;
          res_o.last_byte     = 1'b1;
          res_o.empty_message = 1'b1;
        end else begin
          remaining_d  = length_d;
          in_payload_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_pos_q    <= tlvd_pkg::HdrFirst;
    end else if (beat_i) begin
      in_payload_q <= in_payload_d;
      hdr_pos_q    <= hdr_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i) begin
      type_q      <= type_d;
      length_q    <= length_d;
      remaining_q <= remaining_d;
    end
  end

  assign status_o.in_payload = in_payload_q;
  assign status_o.hdr_pos    = hdr_pos_q;

endmodule

`default_nettype wire

### rtl/tlv_stream_deframer_core.sv
// TLV stream deframer top level: byte input, parser, two-entry result buffer.
//
// Usage:
//   in_i  takes the raw stream, one byte per beat (valid/ready).
//   out_o gives one result per payload byte, or one result marked
//         empty_message for a header whose length is zero. Each result
//         carries the 32-bit type and length of its message and the
//         first_byte / last_byte marks.
//   Header bytes (8 per message, type then length, little-endian) give
//   no result, apart from the empty_message result of a zero-length
//   header. Lengths up to 2^32-1 are counted out in full.
// Throughput: one byte per cycle while a result entry is free; the parser
//   state update is one pass of byte insert plus 32-bit decrement and compare.
// Stall: results sit in an output register backed by a skid register, so
//   in_i.ready stays high while one result waits; it drops only when both
//   entries are full and comes back the cycle after out_o takes one.
// Reset: asynchronous, active low; the parser waits for a header and the
//   result buffer is empty.
`default_nettype none

`include "tlv_stream_deframer_core_defines.svh"

module tlv_stream_deframer_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tlvd_in_if.sink    in_i,
  tlvd_out_if.source out_o
);

  logic              beat;
  logic              push;
  logic              pop;
  logic              res_valid;
  tlvd_pkg::result_t res;
  tlvd_pkg::status_t status;

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  tlvd_pkg::result_t out_q, out_d;
  tlvd_pkg::result_t skid_q, skid_d;

  assign in_i.ready = !skid_valid_q;
  assign beat       = in_i.valid && in_i.ready;
  assign push       = beat && res_valid;
  assign pop        = out_valid_q && out_o.ready;

  tlvd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .data_byte_i (in_i.data_byte),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  // push never coincides with a full skid entry, since ready is low then
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = push;
      end
    end else if (push) begin
      // hold the waiting result, park the new one
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.msg_type      = out_q.msg_type;
  assign out_o.msg_length    = out_q.msg_length;
  assign out_o.payload_byte  = out_q.payload_byte;
  assign out_o.first_byte    = out_q.first_byte;
  assign out_o.last_byte     = out_q.last_byte;
  assign out_o.empty_message = out_q.empty_message;

  `TLVD_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `TLVD_ASSERT_NEXT(a_push_lands, push, out_valid_q, "result lost on push")
  `TLVD_ASSERT_IMPL(a_header_silent, beat && !status.in_payload && status.hdr_pos != tlvd_pkg::HdrLast, !res_valid, "header byte produced a result")
  `TLVD_ASSERT_NEXT(a_last_rearms, push && res.last_byte, !status.in_payload && status.hdr_pos == tlvd_pkg::HdrFirst, "parser not rearmed after last byte")

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the TLV stream deframer: byte stream in, predicted results out.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 30;

  logic clk_i;
  logic rst_ni;

  tlvd_in_if  in_if ();
  tlvd_out_if out_if ();

  tlv_stream_deframer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Deframer state as predicted from the accepted bytes.
  logic [3:0]                 hdr_cnt    = '0;
  logic [tlvd_pkg::WordW-1:0] type_acc   = '0;
  logic [tlvd_pkg::WordW-1:0] len_acc    = '0;
  logic [tlvd_pkg::WordW-1:0] left_cnt   = '0;
  logic                       in_body    = 1'b0;

  tlvd_pkg::result_t expected_q[$];
  int unsigned error_cnt   = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned bytes_sent  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned gap_burst     = 0;
  int unsigned stall_burst   = 0;

  function automatic bit deframe_byte(input logic [tlvd_pkg::ByteW-1:0] b,
                                      output tlvd_pkg::result_t r);
    int unsigned pos;
    r = '0;
    if (in_body) begin
      r.msg_type      = type_acc;
      r.msg_length    = len_acc;
      r.payload_byte  = b;
      r.first_byte    = (left_cnt == len_acc);
      r.last_byte     = (left_cnt == 1);
      r.empty_message = 1'b0;
      left_cnt = left_cnt - 1;
      if (left_cnt == 0) begin
        in_body = 1'b0;
        hdr_cnt = '0;
      end
      return 1'b1;
    end
    pos = hdr_cnt & 7;
    if (pos < 4) begin
      type_acc[8*pos +: 8] = b;
    end else begin
      len_acc[8*(pos-4) +: 8] = b;
    end
    hdr_cnt = 4'(pos + 1);
    if (hdr_cnt >= tlvd_pkg::HdrBytes) begin
      hdr_cnt = '0;
      if (len_acc == 0) begin
        r.msg_type      = type_acc;
        r.msg_length    = len_acc;
        r.payload_byte  = '0;
        r.first_byte    = 1'b1;
        r.last_byte     = 1'b1;
        r.empty_message = 1'b1;
        return 1'b1;
      end
      left_cnt = len_acc;
      in_body  = 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report(input string msg);
    error_cnt++;
    if (error_cnt <= MaxReports) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [tlvd_pkg::WordW-1:0] got,
                               input logic [tlvd_pkg::WordW-1:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic check_result();
    tlvd_pkg::result_t want;
    if (expected_q.size() == 0) begin
      report("result beat with nothing expected");
      return;
    end
    want = expected_q.pop_front();
    compare_field("msg_type", out_if.msg_type, want.msg_type);
    compare_field("msg_length", out_if.msg_length, want.msg_length);
    compare_field("payload_byte", out_if.payload_byte, want.payload_byte);
    compare_field("first_byte", out_if.first_byte, want.first_byte);
    compare_field("last_byte", out_if.last_byte, want.last_byte);
    compare_field("empty_message", out_if.empty_message, want.empty_message);
  endtask

  // Result side: check each beat, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      check_result();
    end
    if (stall_burst > 0) begin
      stall_burst--;
      out_if.ready <= 1'b0;
    end else if (stall_pct > 0 && $urandom_range(99) < 3) begin
      stall_burst = $urandom_range(30, 8);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [tlvd_pkg::ByteW-1:0] b);
    tlvd_pkg::result_t r;
    if (send_idle_pct > 0 && $urandom_range(99) < 3) begin
      // long sender gap
      gap_burst = $urandom_range(30, 8);
      in_if.valid <= 1'b0;
      repeat (gap_burst) @(posedge clk_i);
    end else begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (deframe_byte(b, r)) begin
      expected_q.push_back(r);
    end
    bytes_sent++;
  endtask

  task automatic send_header(input logic [tlvd_pkg::WordW-1:0] msg_type,
                             input logic [tlvd_pkg::WordW-1:0] len);
    for (int i = 0; i < 4; i++) send_byte(msg_type[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
  endtask

  // Hold the input until every expected result has been taken.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_zero_length();
    send_header(32'hFFFF_FFFF, 32'h0);
  endtask

  task automatic test_short_payloads();
    send_header(32'h0, 32'h1);
    send_byte(8'hFF);
    send_header(32'h5A5A_00A5, 32'h2);
    send_byte(8'h00);
    send_byte(8'h80);
  endtask

  task automatic test_random_messages(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    logic [tlvd_pkg::WordW-1:0] msg_type;
    logic [tlvd_pkg::WordW-1:0] len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        len = 0;
      end else if (pick < 85) begin
        len = $urandom_range(6, 1);
      end else begin
        len = $urandom_range(40, 7);
      end
      pick = $urandom_range(9);
      msg_type = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
      send_header(msg_type, len);
      for (int unsigned i = 0; i < len; i++) begin
        pick = $urandom_range(9);
        send_byte((pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_idle_phases();
    int unsigned idle_set[4]  = '{0, 46, 0, 24};
    int unsigned stall_set[4] = '{0, 0, 46, 24};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      test_random_messages(150);
      wait_drained();
    end
  endtask

  // The stream never leaves this payload, so it must be the last test.
  task automatic test_largest_length();
    send_header($urandom, 32'hFFFF_FFFF);
    repeat (16) send_byte(8'($urandom_range(255)));
  endtask

  task automatic finish_run();
    send_idle_pct = 0;
    stall_pct     = 0;
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_cnt == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_length();
    test_short_payloads();
    wait_drained();
    test_idle_phases();
    test_largest_length();
    finish_run();
  end

endmodule

`default_nettype wire
